@@ rtl/texture_tile_swizzle_convert_top_defines.svh @@
// assertion macros for the texture tile swizzle and convert block
// expects clk and arst_n in the scope of each use
`ifndef TEXTURE_TILE_SWIZZLE_CONVERT_TOP_DEFINES_SVH
`define TEXTURE_TILE_SWIZZLE_CONVERT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TSC_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsc: same-cycle check failed");
`define TSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsc: next-cycle check failed");
`else
`define TSC_ASSERT_IMPLIES(label, ante, cons)
`define TSC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/tsc_pkg.sv @@
// shared types, constants and pixel conversion for the tile swizzle block
// no dependencies
`timescale 1ns / 1ps

package tsc_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int TILE_ROWS   = 4;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(TILE_ROWS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int STORE_DEPTH = TILE_ROWS * MAX_WIDTH;
	localparam int WL_W        = 4;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int STEP_W      = 4;

	localparam logic [WL_W-1:0] WL_MIN = WL_W'(3);
	localparam logic [WL_W-1:0] WL_MAX = WL_W'(COL_W);

	localparam logic REG_SOURCE_FORMAT = 1'b0;
	localparam logic REG_WIDTH_LOG2    = 1'b1;

	typedef enum logic [2:0] {
		FMT_RGB565   = 3'd0,
		FMT_RGBA4444 = 3'd1,
		FMT_RGBA5551 = 3'd2,
		FMT_LA88     = 3'd3,
		FMT_L8       = 3'd4,
		FMT_RGBA8888 = 3'd5,
		FMT_RGB888   = 3'd6
	} fmt_t;

	typedef struct packed {
		fmt_t             fmt;
		logic [COL_W-1:0] base;
	} tile_cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} store_wr_t;

	typedef struct packed {
		logic                         full;
		logic                         nonempty;
		logic [QDEPTH-1:0]            used;
		logic [QDEPTH-1:0][COL_W-1:0] base;
	} queue_stat_t;

	typedef struct packed {
		logic             busy;
		logic [COL_W-1:0] base;
	} back_stat_t;

	function automatic logic is_wide(input fmt_t fmt);
		return (fmt == FMT_RGBA8888) || (fmt == FMT_RGB888);
	endfunction

	function automatic logic [4:0] widen4(input logic [3:0] v);
		return {v, v[3]};
	endfunction

	function automatic logic [31:0] convert_pixel(input fmt_t fmt, input logic [31:0] p);
		logic [31:0] res;
		res = 32'd0;
		case (fmt)
			FMT_RGBA4444: begin
				if (p[3:0] == 4'hF)
					res = {16'd0, 1'b1, widen4(p[15:12]), widen4(p[11:8]), widen4(p[7:4])};
				else
					res = {16'd0, 1'b0, p[3:1], p[15:4]};
			end
			FMT_RGBA5551: begin
				res = p[0] ? {16'd0, 1'b1, p[15:1]} : 32'd0;
			end
			FMT_LA88:     res = {16'd0, p[7:0], p[15:8]};
			FMT_L8:       res = {24'd0, p[7:0]};
			FMT_RGBA8888: res = {p[7:0], p[31:8]};
			FMT_RGB888:   res = {8'hFF, p[7:0], p[23:16], p[15:8]};
			default:      res = {16'd0, p[15:0]};
		endcase
		return res;
	endfunction

endpackage

@@ rtl/tsc_front.sv @@
// front end: accepts pixels, converts them, tracks band position, issues tile commands
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tsc_pkg::fmt_t          source_format,
	input  logic [3:0]             width_log2,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [31:0]            pixel_word,
	input  tsc_pkg::queue_stat_t   q_stat,
	input  tsc_pkg::back_stat_t    b_stat,
	output tsc_pkg::store_wr_t     wr,
	output logic                   push,
	output tsc_pkg::tile_cmd_t     cmd
);

	logic [tsc_pkg::COL_W-1:0] col_q;
	logic [tsc_pkg::ROW_W-1:0] row_q;
	logic [tsc_pkg::WL_W-1:0]  eff_wl;
	logic [tsc_pkg::COL_W:0]   w_full;
	logic [tsc_pkg::COL_W:0]   w_last_full;
	logic [tsc_pkg::COL_W-1:0] col_last;
	logic [tsc_pkg::COL_W-1:0] col_eff;
	logic [tsc_pkg::COL_W-1:0] grp_mask;
	logic [tsc_pkg::COL_W-1:0] grp;
	logic                      tile_end;
	logic                      hit;
	logic                      accept;

	always_comb begin
		if (width_log2 < tsc_pkg::WL_MIN)
			eff_wl = tsc_pkg::WL_MIN;
		else if (width_log2 > tsc_pkg::WL_MAX)
			eff_wl = tsc_pkg::WL_MAX;
		else
			eff_wl = width_log2;
	end

	assign w_full      = (tsc_pkg::COL_W+1)'(1) << eff_wl;
	assign w_last_full = w_full - (tsc_pkg::COL_W+1)'(1);
	assign col_last    = w_last_full[tsc_pkg::COL_W-1:0];
	assign col_eff     = ({1'b0, col_q} >= w_full) ? '0 : col_q;

	assign grp_mask = (source_format == tsc_pkg::FMT_L8) ?
		~tsc_pkg::COL_W'(7) : ~tsc_pkg::COL_W'(3);
	assign grp      = col_eff & grp_mask;
	assign tile_end = (row_q == tsc_pkg::ROW_W'(tsc_pkg::TILE_ROWS - 1)) &&
		((col_eff | grp_mask) == '1);

	// a write may not land in a column group that a queued or active tile still reads
	always_comb begin
		hit = b_stat.busy && (b_stat.base == grp);
		for (int i = 0; i < tsc_pkg::QDEPTH; i++) begin
			if (q_stat.used[i] && (q_stat.base[i] == grp))
				hit = 1'b1;
		end
	end

	assign in_stall = hit || (tile_end && q_stat.full);
	assign accept   = in_valid && !in_stall;

	assign wr.en    = accept;
	assign wr.addr  = {row_q, col_eff};
	assign wr.data  = tsc_pkg::convert_pixel(source_format, pixel_word);
	assign push     = accept && tile_end;
	assign cmd.fmt  = source_format;
	assign cmd.base = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_eff == col_last) begin
				col_q <= '0;
				row_q <= row_q + tsc_pkg::ROW_W'(1);
			end else begin
				col_q <= col_eff + tsc_pkg::COL_W'(1);
			end
		end
	end

endmodule

@@ rtl/tsc_queue.sv @@
// short command queue between front and back, exposes pending tile columns
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tsc_pkg::tile_cmd_t   cmd_in,
	input  logic                 pop,
	output tsc_pkg::tile_cmd_t   cmd_out,
	output tsc_pkg::queue_stat_t stat
);

	tsc_pkg::tile_cmd_t         entry_q [tsc_pkg::QDEPTH];
	logic [tsc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tsc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tsc_pkg::QPTR_W:0]   count_q;
	logic [tsc_pkg::QPTR_W-1:0] offset;

	always_comb begin
		offset        = '0;
		stat.full     = (count_q == (tsc_pkg::QPTR_W+1)'(tsc_pkg::QDEPTH));
		stat.nonempty = (count_q != '0);
		for (int i = 0; i < tsc_pkg::QDEPTH; i++) begin
			offset = tsc_pkg::QPTR_W'(i) - rd_ptr_q;
			stat.used[i] = ({1'b0, offset} < count_q);
			stat.base[i] = entry_q[i].base;
		end
	end

	assign cmd_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + tsc_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + tsc_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (tsc_pkg::QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (tsc_pkg::QPTR_W+1)'(1);
		end
	end

endmodule

@@ rtl/tsc_back.sv @@
// back end: band store, tile read sequencer, word packing and output register
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tsc_pkg::store_wr_t  wr,
	input  logic                q_nonempty,
	input  tsc_pkg::tile_cmd_t  cmd_in,
	output logic                pop,
	output tsc_pkg::back_stat_t stat,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         tile_word,
	output logic                tile_last
);

	localparam logic [tsc_pkg::STEP_W-1:0] STEP_LAST_SHORT = tsc_pkg::STEP_W'(7);
	localparam logic [tsc_pkg::STEP_W-1:0] STEP_LAST_LONG  = tsc_pkg::STEP_W'(15);

	logic [31:0] mem [tsc_pkg::STORE_DEPTH];

	logic                        busy_q;
	tsc_pkg::tile_cmd_t          cmd_q;
	logic [tsc_pkg::STEP_W-1:0]  step_q;
	logic [tsc_pkg::STEP_W-1:0]  last_step;
	logic [tsc_pkg::ROW_W-1:0]   rd_row;
	logic [2:0]                  rd_ofs;
	logic [tsc_pkg::COL_W-1:0]   col0;
	logic [tsc_pkg::ADDR_W-1:0]  addr0;
	logic [tsc_pkg::ADDR_W-1:0]  addr1;
	logic                        issue;

	logic                        valid_s1;
	tsc_pkg::fmt_t               fmt_s1;
	logic [tsc_pkg::STEP_W-1:0]  step_s1;
	logic                        last_s1;
	logic [31:0]                 rd0_s1;
	logic [31:0]                 rd1_s1;
	logic [15:0]                 hold_q;
	logic                        emits_s1;
	logic                        adv_s1;
	logic [31:0]                 word;

	logic                        out_valid_q;
	logic [31:0]                 tile_word_q;
	logic                        tile_last_q;

	assign last_step = (tsc_pkg::is_wide(cmd_q.fmt) || (cmd_q.fmt == tsc_pkg::FMT_L8)) ?
		STEP_LAST_LONG : STEP_LAST_SHORT;

	// each step reads one texel pair of the tile
	always_comb begin
		if (cmd_q.fmt == tsc_pkg::FMT_L8) begin
			rd_row = step_q[3:2];
			rd_ofs = {step_q[1:0], 1'b0};
		end else begin
			rd_row = step_q[2:1];
			rd_ofs = {1'b0, step_q[0], 1'b0};
		end
	end

	assign col0  = cmd_q.base + tsc_pkg::COL_W'(rd_ofs);
	assign addr0 = {rd_row, col0};
	assign addr1 = {rd_row, col0[tsc_pkg::COL_W-1:1], 1'b1};

	assign emits_s1 = !((fmt_s1 == tsc_pkg::FMT_L8) && !step_s1[0]);
	assign adv_s1   = valid_s1 && (!emits_s1 || !out_valid_q || !out_stall);
	assign issue    = busy_q && (!valid_s1 || adv_s1);
	assign pop      = q_nonempty && (!busy_q || (issue && (step_q == last_step)));

	assign stat.busy = busy_q;
	assign stat.base = cmd_q.base;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (issue) begin
			rd0_s1 <= mem[addr0];
			rd1_s1 <= mem[addr1];
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= cmd_in;
		if (issue) begin
			fmt_s1  <= cmd_q.fmt;
			step_s1 <= step_q;
			last_s1 <= (step_q == last_step);
		end
		if (adv_s1 && !emits_s1)
			hold_q <= {rd0_s1[7:0], rd1_s1[7:0]};
		if (adv_s1 && emits_s1) begin
			tile_word_q <= word;
			tile_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (issue) begin
				if (step_q == last_step)
					busy_q <= 1'b0;
				else
					step_q <= step_q + tsc_pkg::STEP_W'(1);
			end
			if (issue)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1 && emits_s1)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		case (fmt_s1)
			tsc_pkg::FMT_L8: word = {hold_q, rd0_s1[7:0], rd1_s1[7:0]};
			tsc_pkg::FMT_RGBA8888,
			tsc_pkg::FMT_RGB888: begin
				// ar halves first, gb halves in the second pass
				word = step_s1[3] ? {rd0_s1[15:0], rd1_s1[15:0]} :
					{rd0_s1[31:16], rd1_s1[31:16]};
			end
			default: word = {rd0_s1[15:0], rd1_s1[15:0]};
		endcase
	end

	assign out_valid = out_valid_q;
	assign tile_word = tile_word_q;
	assign tile_last = tile_last_q;

endmodule

@@ rtl/texture_tile_swizzle_convert_top.sv @@
// a finished tile goes through queue, command register, store read stage and output register
// throughput: one pixel per cycle in unless stalled; back reads one texel pair per cycle,
// while the output is free, from a 1w/2r band store: one word per pair (l8: per two pairs)
// input stalls when a row would overwrite an unread tile, or a finished tile meets a full queue
// reset clears position, queue, sequencer and output valid; the band store is not cleared
`timescale 1ns / 1ps
`include "texture_tile_swizzle_convert_top_defines.svh"

module texture_tile_swizzle_convert_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pixel_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] tile_word,
	output logic        tile_last
);

	tsc_pkg::fmt_t        source_format_q;
	logic [3:0]           width_log2_q;
	logic                 cfg_wr;
	tsc_pkg::store_wr_t   wr;
	logic                 q_push;
	logic                 q_pop;
	tsc_pkg::tile_cmd_t   push_cmd;
	tsc_pkg::tile_cmd_t   head_cmd;
	tsc_pkg::queue_stat_t q_stat;
	tsc_pkg::back_stat_t  b_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= tsc_pkg::FMT_RGB565;
			width_log2_q    <= 4'd3;
		end else if (cfg_wr) begin
			if (paddr[2] == tsc_pkg::REG_SOURCE_FORMAT)
				source_format_q <= tsc_pkg::fmt_t'(pwdata[2:0]);
			else
				width_log2_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == tsc_pkg::REG_WIDTH_LOG2) ?
		{28'd0, width_log2_q} : {29'd0, source_format_q};

	tsc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_format (source_format_q),
		.width_log2    (width_log2_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_word    (pixel_word),
		.q_stat        (q_stat),
		.b_stat        (b_stat),
		.wr            (wr),
		.push          (q_push),
		.cmd           (push_cmd)
	);

	tsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (push_cmd),
		.pop     (q_pop),
		.cmd_out (head_cmd),
		.stat    (q_stat)
	);

	tsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.q_nonempty (q_stat.nonempty),
		.cmd_in     (head_cmd),
		.pop        (q_pop),
		.stat       (b_stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tile_word  (tile_word),
		.tile_last  (tile_last)
	);

	`TSC_ASSERT_IMPLIES(a_queue_push_room, q_push, !q_stat.full)
	`TSC_ASSERT_IMPLIES(a_queue_pop_data, q_pop, q_stat.nonempty)
	`TSC_ASSERT_NEXT(a_push_seen_by_back, q_push, q_stat.nonempty || b_stat.busy)

endmodule

@@ tb/tb.sv @@
// self-checking testbench for texture_tile_swizzle_convert_top
// depends on tsc_pkg and the block rtl; a scoreboard class predicts every tile word
`timescale 1ns / 1ps

module tb;

	localparam logic [2:0] FMT_SPARE = 3'd7;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_ITEMS = 96;

	class tile_scoreboard;
		logic [31:0] band_texels [tsc_pkg::STORE_DEPTH];
		int unsigned col_pos;
		int unsigned row_pos;
		logic [2:0] fmt_code;
		logic [3:0] width_code;
		logic [32:0] due_tile_words [$];
		int errors;
		int words_checked;
		int tiles_predicted;

		function new();
			col_pos = 0;
			row_pos = 0;
			fmt_code = tsc_pkg::FMT_RGB565;
			width_code = 4'd3;
			errors = 0;
			words_checked = 0;
			tiles_predicted = 0;
		endfunction

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == tsc_pkg::REG_SOURCE_FORMAT)
				fmt_code = value[2:0];
			else
				width_code = value[3:0];
		endfunction

		function int unsigned row_width();
			int unsigned w;
			w = 1 << width_code;
			if (w > tsc_pkg::MAX_WIDTH)
				w = tsc_pkg::MAX_WIDTH;
			if (w < 8)
				w = 8;
			return w;
		endfunction

		function logic [4:0] spread4(logic [3:0] v);
			return (5'(v) << 1) | 5'(v >> 3);
		endfunction

		function logic [31:0] to_texel(logic [2:0] f, logic [31:0] p);
			logic [31:0] t;
			case (f)
				tsc_pkg::FMT_RGBA4444: begin
					if (p[3:0] == 4'hF)
						t = 32'h8000 | (32'(spread4(p[15:12])) << 10) |
							(32'(spread4(p[11:8])) << 5) | 32'(spread4(p[7:4]));
					else
						t = (32'(p[3:1]) << 12) | 32'(p[15:4]);
				end
				tsc_pkg::FMT_RGBA5551: t = p[0] ? (32'h8000 | 32'(p[15:1])) : 32'h0;
				tsc_pkg::FMT_LA88:     t = 32'({p[7:0], p[15:8]});
				tsc_pkg::FMT_L8:       t = 32'(p[7:0]);
				tsc_pkg::FMT_RGBA8888: t = (p << 24) | (p >> 8);
				tsc_pkg::FMT_RGB888: begin
					t = 32'hFF00_0000 | (32'(p[7:0]) << 16) | (32'(p[23:16]) << 8) |
						32'(p[15:8]);
				end
				default:      t = p & 32'h0000_FFFF;
			endcase
			return t;
		endfunction

		function void note_pixel(logic [31:0] p);
			logic [31:0] tex [32];
			logic [31:0] word;
			int unsigned w, tw, x0, k, words;
			w = row_width();
			tw = (fmt_code == tsc_pkg::FMT_L8) ? 8 : 4;
			if (col_pos >= w)
				col_pos = 0;
			band_texels[row_pos * tsc_pkg::MAX_WIDTH + col_pos] = to_texel(fmt_code, p);
			if (row_pos == tsc_pkg::TILE_ROWS - 1 && col_pos % tw == tw - 1) begin
				x0 = col_pos - (tw - 1);
				for (k = 0; k < tw * tsc_pkg::TILE_ROWS; k++)
					tex[k] = band_texels[(k / tw) * tsc_pkg::MAX_WIDTH + x0 + k % tw];
				words = (fmt_code == tsc_pkg::FMT_RGBA8888 ||
					fmt_code == tsc_pkg::FMT_RGB888) ? 16 : 8;
				for (k = 0; k < words; k++) begin
					// wide formats: alpha/red halves first, then green/blue halves
					if (words == 16 && k < 8)
						word = {tex[2*k][31:16], tex[2*k+1][31:16]};
					else if (words == 16)
						word = {tex[2*(k-8)][15:0], tex[2*(k-8)+1][15:0]};
					else if (tw == 8)
						word = {tex[4*k][7:0], tex[4*k+1][7:0], tex[4*k+2][7:0], tex[4*k+3][7:0]};
					else
						word = {tex[2*k][15:0], tex[2*k+1][15:0]};
					due_tile_words.push_back({(k == words - 1), word});
				end
				tiles_predicted++;
			end
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos = (row_pos + 1) % tsc_pkg::TILE_ROWS;
			end
		endfunction

		function void check_word(logic [31:0] word, logic last);
			logic [32:0] due;
			words_checked++;
			if (due_tile_words.size() == 0) begin
				errors++;
				$display("%0t: tile_word expected none, actual %h", $time, word);
				return;
			end
			due = due_tile_words.pop_front();
			if (word !== due[31:0]) begin
				errors++;
				$display("%0t: tile_word expected %h, actual %h", $time, due[31:0], word);
			end
			if (last !== due[32]) begin
				errors++;
				$display("%0t: tile_last expected %b, actual %b", $time, due[32], last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] pixel_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] tile_word;
	logic        tile_last;

	bit hold_req = 1'b0;
	bit sender_gapless = 1'b0;
	int pixels_sent = 0;
	int cfg_writes = 0;
	tile_scoreboard sb;

	logic [31:0] corner_pixels [14] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
		32'h0000_000F, 32'h0000_FFFE, 32'h0000_0001, 32'h8000_0000,
		32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000,
		32'h1234_567E, 32'h0000_8421
	};
	// paired by band: the second code of a pair reads the first one's texels in full
	logic [2:0] format_codes [8] = '{
		tsc_pkg::FMT_RGB565, tsc_pkg::FMT_RGBA4444, tsc_pkg::FMT_RGBA5551, tsc_pkg::FMT_LA88,
		tsc_pkg::FMT_L8, FMT_SPARE, tsc_pkg::FMT_RGBA8888, tsc_pkg::FMT_RGB888
	};

	texture_tile_swizzle_convert_top dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_pixel(pixel_word);
			if (out_valid && !out_stall)
				sb.check_word(tile_word, tile_last);
		end
	end

	initial begin : receiver_stall
		int r, len;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				len = HOLD_OFF_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					out_stall <= 1'b0;
					len = $urandom_range(8, 60);
				end else if (r < 85) begin
					out_stall <= 1'($urandom_range(0, 1));
					len = $urandom_range(1, 3);
				end else begin
					out_stall <= 1'b1;
					len = $urandom_range(4, 30);
				end
			end
			repeat (len) @(posedge clk);
		end
	end

	function automatic logic [31:0] random_pixel();
		logic [31:0] p;
		p = $urandom;
		// opaque rgba4444 is rare otherwise
		if (sb.fmt_code == tsc_pkg::FMT_RGBA4444 && $urandom_range(0, 1) == 1)
			p[3:0] = 4'hF;
		return p;
	endfunction

	task automatic send_pixel(input logic [31:0] p);
		int gap;
		if (sender_gapless)
			gap = 0;
		else if ($urandom_range(0, 9) < 8)
			gap = $urandom_range(0, 2);
		else
			gap = $urandom_range(3, 25);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_word <= p;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_pixel(random_pixel());
	endtask

	// wait for every due word, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_tile_words.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [2:0] f, input logic [3:0] wl);
		drain();
		apb_write(tsc_pkg::REG_SOURCE_FORMAT, 32'(f));
		apb_write(tsc_pkg::REG_WIDTH_LOG2, 32'(wl));
	endtask

	initial begin : stimulus
		int i, k, r, wl_pick, items, cut, count;
		bit first;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner values, two format codes per band at the narrowest width
		// width code 0 clamps to 8 for the first two bands
		for (i = 0; i < 8; i++) begin
			set_mode(format_codes[i], (i < 4) ? 4'd0 : 4'd3);
			for (k = 0; k < 16; k++)
				send_pixel(k < 14 ? corner_pixels[k] : random_pixel());
		end

		// widest rows, then shrink so the column restarts
		set_mode(tsc_pkg::FMT_LA88, 4'd10);
		send_random(12);
		drain();
		apb_write(tsc_pkg::REG_WIDTH_LOG2, 32'd3);
		send_random(32);
		set_mode(tsc_pkg::FMT_RGB888, 4'd15);
		send_random(12);
		drain();
		apb_write(tsc_pkg::REG_WIDTH_LOG2, 32'd0);
		send_random(32);

		// shrink mid row with earlier rows kept
		set_mode(tsc_pkg::FMT_RGBA5551, 4'd4);
		send_random(43);
		drain();
		apb_write(tsc_pkg::REG_WIDTH_LOG2, 32'd3);
		send_random(16);

		// format change on the last row of a band
		set_mode(tsc_pkg::FMT_L8, 4'd4);
		send_random(54);
		drain();
		apb_write(tsc_pkg::REG_SOURCE_FORMAT, 32'(tsc_pkg::FMT_RGBA8888));
		send_random(10);

		count = 0;
		first = 1'b1;
		while (count < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			wl_pick = (r < 60) ? 3 : 4;
			if (first)
				wl_pick = 4;
			set_mode(3'($urandom_range(0, 7)), 4'(wl_pick));
			items = 4 << wl_pick;
			sender_gapless = first || ($urandom_range(0, 3) == 0);
			// long receiver hold-off while requests keep coming
			if (first) begin
				hold_req = 1'b1;
				wait (!hold_req);
			end
			if ($urandom_range(0, 2) == 0) begin
				cut = $urandom_range(1, items - 1);
				send_random(cut);
				drain();
				apb_write(tsc_pkg::REG_SOURCE_FORMAT, 32'($urandom_range(0, 7)));
				send_random(items - cut);
			end else begin
				send_random(items);
			end
			count += items;
			first = 1'b0;
		end
		sender_gapless = 1'b0;

		drain();
		$display("run: %0d pixels, all format codes, widths 8 to 1024, %0d register writes",
			pixels_sent, cfg_writes);
		$display("run: %0d tiles and %0d words compared", sb.tiles_predicted, sb.words_checked);
		if (sb.errors == 0 && sb.due_tile_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
